FILE: rtl/servo_ease_in_out_trajectory_unit_defines.svh
// Assertion macros for the servo ease-in-out trajectory unit.
`ifndef SERVO_EASE_IN_OUT_TRAJECTORY_UNIT_DEFINES_SVH
`define SERVO_EASE_IN_OUT_TRAJECTORY_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clk, quiet during reset.
`define SEIO_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on clk, quiet during reset.
`define SEIO_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/seio_pkg.sv
// Shared types and constants of the servo ease-in-out trajectory unit.
`default_nettype none
package seio_pkg;

	localparam int unsigned DIV_W = 24;               // dividend and quotient width
	localparam logic [15:0] DEG_FULL = 16'd180;
	localparam logic [15:0] PULSE_MIN_RST = 16'd500;
	localparam logic [15:0] PULSE_MAX_RST = 16'd2500;

	localparam logic FUNC_START = 1'b0;
	localparam logic FUNC_TICK  = 1'b1;

	localparam logic REG_PULSE_MIN = 1'b0;
	localparam logic REG_PULSE_MAX = 1'b1;

	typedef enum logic [1:0] {
		DIV_INT = 2'd0,   // duration / steps
		DIV_ANG = 2'd1,   // eased numerator / steps^2
		DIV_CMP = 2'd2    // |angle * span| / 180
	} div_sel_t;

	typedef struct packed {
		logic     load;
		logic     tick_inc;
		logic     step_adv;
		logic     set_int;
		logic     calc_f;
		logic     calc_num;
		logic     div_go;
		div_sel_t div_sel;
		logic     lat_angle;
		logic     calc_prod;
		logic     emit;
	} cmd_t;

	typedef struct packed {
		logic moving;
		logic tick_hit;
		logic div_done;
		logic out_busy;
	} sts_t;

endpackage
`default_nettype wire

FILE: rtl/seio_div.sv
// Constant divider: multiply by a fixed reciprocal, then shift.
`default_nettype none
module seio_div #(
	parameter int unsigned STEPS = 200
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        go,
	input  wire seio_pkg::div_sel_t          sel,
	input  wire logic [seio_pkg::DIV_W-1:0]  dividend,
	output logic      [seio_pkg::DIV_W-1:0]  quotient,
	output logic                             done
);
	// Reciprocal ceil(2^sh / d) with sh = DIV_W + clog2(d): its error stays below d,
	// so the shifted product is the exact floor for any dividend under 2^DIV_W.
	localparam int unsigned RCP_W = seio_pkg::DIV_W + 1;
	localparam int unsigned PRD_W = seio_pkg::DIV_W + RCP_W;
	localparam longint unsigned DV_INT = 64'(STEPS);
	localparam longint unsigned DV_ANG = 64'(STEPS) * 64'(STEPS);
	localparam longint unsigned DV_CMP = 64'(seio_pkg::DEG_FULL);
	localparam int unsigned SH_INT = seio_pkg::DIV_W + $clog2(DV_INT);
	localparam int unsigned SH_ANG = seio_pkg::DIV_W + $clog2(DV_ANG);
	localparam int unsigned SH_CMP = seio_pkg::DIV_W + $clog2(DV_CMP);
	localparam logic [RCP_W-1:0] RCP_INT =
		RCP_W'(((64'd1 << SH_INT) + DV_INT - 64'd1) / DV_INT);
	localparam logic [RCP_W-1:0] RCP_ANG =
		RCP_W'(((64'd1 << SH_ANG) + DV_ANG - 64'd1) / DV_ANG);
	localparam logic [RCP_W-1:0] RCP_CMP =
		RCP_W'(((64'd1 << SH_CMP) + DV_CMP - 64'd1) / DV_CMP);

	logic                          busy_q;
	logic                          done_q;
	seio_pkg::div_sel_t            sel_q;
	logic [seio_pkg::DIV_W-1:0]    opd_q;
	logic [PRD_W-1:0]              prod_q;
	logic [RCP_W-1:0]              rcp;

	always_comb begin
		unique case (sel_q)
			seio_pkg::DIV_INT: begin
				rcp      = RCP_INT;
				quotient = seio_pkg::DIV_W'(prod_q >> SH_INT);
			end
			seio_pkg::DIV_ANG: begin
				rcp      = RCP_ANG;
				quotient = seio_pkg::DIV_W'(prod_q >> SH_ANG);
			end
			default: begin
				rcp      = RCP_CMP;
				quotient = seio_pkg::DIV_W'(prod_q >> SH_CMP);
			end
		endcase
	end

	// go: operand in; next cycle: product; done the cycle after.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			sel_q  <= seio_pkg::DIV_INT;
		end else begin
			busy_q <= go;
			done_q <= busy_q;
			if (go)
				sel_q <= sel;
		end
	end

	// 24 x 25 unsigned product.
	always_ff @(posedge clk) begin
		if (go)
			opd_q <= dividend;
		if (busy_q)
			prod_q <= PRD_W'(opd_q) * PRD_W'(rcp);
	end

	assign done = done_q;

endmodule
`default_nettype wire

FILE: rtl/seio_dp.sv
// Datapath: move state, easing arithmetic, pulse mapping and output register.
`default_nettype none
module seio_dp #(
	parameter int unsigned STEPS = 200
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic                  cfg_index,
	input  wire logic [15:0]           cfg_data,
	input  wire logic [7:0]            start_angle,
	input  wire logic [7:0]            end_angle,
	input  wire logic [15:0]           duration_ms,
	input  wire logic [1:0]            channel,
	input  wire seio_pkg::cmd_t        cmd,
	output seio_pkg::sts_t             sts,
	input  wire logic                  out_stall,
	output logic                       out_valid,
	output logic [15:0]                compare_value,
	output logic [1:0]                 out_channel,
	output logic [7:0]                 step_index,
	output logic                       last
);
	localparam int unsigned IW = $clog2(65535 / STEPS + 1);
	localparam logic [15:0] D_SQ   = 16'(STEPS * STEPS);
	localparam logic [7:0]  STEP_N = 8'(STEPS);

	logic [15:0]                     pulse_min_q, pulse_max_q;
	logic                            moving_q;
	logic [7:0]                      step_q;
	logic [IW-1:0]                   tick_q, interval_q;
	logic [7:0]                      start_q, end_q;
	logic [1:0]                      chan_q;
	logic [15:0]                     f_q;
	logic [seio_pkg::DIV_W-1:0]      num_q;
	logic [7:0]                      angle_q;
	logic signed [25:0]              prod_q;
	logic                            out_valid_q;
	logic [15:0]                     cmp_q;
	logic [1:0]                      och_q;
	logic [7:0]                      sidx_q;
	logic                            last_q;

	logic [IW:0]                     tick_inc;
	logic [15:0]                     ii;
	logic [18:0]                     f_hi;
	logic [15:0]                     f_nxt;
	logic [seio_pkg::DIV_W-1:0]      base;
	logic signed [8:0]               delta;
	logic signed [25:0]              dprod;
	logic signed [25:0]              num_sum;
	logic signed [16:0]              span;
	logic signed [25:0]              mag;
	logic [seio_pkg::DIV_W-1:0]      dv_dividend;
	logic [seio_pkg::DIV_W-1:0]      dv_quo;
	logic                            dv_done;
	logic [15:0]                     q16, term;
	logic [IW-1:0]                   int_q;

	// Config registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_min_q <= seio_pkg::PULSE_MIN_RST;
			pulse_max_q <= seio_pkg::PULSE_MAX_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				seio_pkg::REG_PULSE_MIN: pulse_min_q <= cfg_data;
				seio_pkg::REG_PULSE_MAX: pulse_max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Easing numerator pieces.
	assign ii    = 16'({8'd0, step_q} * {8'd0, step_q});
	assign f_hi  = 19'(19'(step_q) * 19'(STEPS) * 19'd4) - 19'({ii, 1'b0}) - 19'(D_SQ);
	assign f_nxt = ({1'b0, step_q, 1'b0} < 10'(STEPS)) ? 16'({ii, 1'b0}) : f_hi[15:0];

	assign base    = seio_pkg::DIV_W'(start_q) * seio_pkg::DIV_W'(D_SQ);
	assign delta   = $signed({1'b0, end_q}) - $signed({1'b0, start_q});
	assign dprod   = 26'($signed({{17{delta[8]}}, delta}) * $signed({10'd0, f_q}));
	assign num_sum = $signed({2'b0, base}) + dprod;

	assign span = $signed({1'b0, pulse_max_q}) - $signed({1'b0, pulse_min_q});
	assign mag  = prod_q[25] ? -prod_q : prod_q;

	always_comb begin
		unique case (cmd.div_sel)
			seio_pkg::DIV_INT: begin
				dv_dividend = seio_pkg::DIV_W'(duration_ms);
			end
			seio_pkg::DIV_ANG: begin
				dv_dividend = num_q;
			end
			seio_pkg::DIV_CMP: begin
				dv_dividend = mag[seio_pkg::DIV_W-1:0];
			end
			default: begin
				dv_dividend = '0;
			end
		endcase
	end

	seio_div #(
		.STEPS (STEPS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (cmd.div_go),
		.sel      (cmd.div_sel),
		.dividend (dv_dividend),
		.quotient (dv_quo),
		.done     (dv_done)
	);

	assign int_q    = dv_quo[IW-1:0];
	assign tick_inc = {1'b0, tick_q} + 1'b1;

	// Truncating divide: restore the sign, then wrap to 16 bits.
	assign q16  = dv_quo[15:0];
	assign term = prod_q[25] ? 16'(16'd0 - q16) : q16;

	// Move state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			moving_q   <= 1'b0;
			step_q     <= '0;
			tick_q     <= '0;
			interval_q <= '0;
		end else begin
			if (cmd.load) begin
				moving_q <= 1'b1;
				step_q   <= '0;
				tick_q   <= '0;
			end
			if (cmd.tick_inc)
				tick_q <= tick_inc[IW-1:0];
			if (cmd.step_adv) begin
				tick_q <= '0;
				step_q <= step_q + 1'b1;
			end
			if (cmd.set_int)
				interval_q <= (int_q == '0) ? IW'(1) : int_q;
			if (cmd.emit && step_q == STEP_N)
				moving_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			start_q <= start_angle;
			end_q   <= end_angle;
			chan_q  <= channel;
		end
		if (cmd.calc_f)
			f_q <= f_nxt;
		if (cmd.calc_num)
			num_q <= num_sum[seio_pkg::DIV_W-1:0];
		if (cmd.lat_angle)
			angle_q <= dv_quo[7:0];
		if (cmd.calc_prod)
			prod_q <= 26'($signed({18'd0, angle_q}) * $signed({{9{span[16]}}, span}));
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			cmp_q  <= pulse_min_q + term;
			och_q  <= chan_q;
			sidx_q <= step_q;
			last_q <= (step_q == STEP_N);
		end
	end

	assign sts.moving   = moving_q;
	assign sts.tick_hit = (tick_inc >= {1'b0, interval_q});
	assign sts.div_done = dv_done;
	assign sts.out_busy = out_valid_q && out_stall;

	assign out_valid     = out_valid_q;
	assign compare_value = cmp_q;
	assign out_channel   = och_q;
	assign step_index    = sidx_q;
	assign last          = last_q;

endmodule
`default_nettype wire

FILE: rtl/seio_ctrl.sv
// Controller: sequences request handling and the datapath steps.
`default_nettype none
module seio_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire logic            func,
	output logic                 in_stall,
	output seio_pkg::cmd_t       cmd,
	input  wire seio_pkg::sts_t  sts
);
	typedef enum logic [9:0] {
		S_IDLE  = 10'b00_0000_0001,
		S_DIVI  = 10'b00_0000_0010,
		S_CALCF = 10'b00_0000_0100,
		S_NUM   = 10'b00_0000_1000,
		S_GOA   = 10'b00_0001_0000,
		S_DIVA  = 10'b00_0010_0000,
		S_PROD  = 10'b00_0100_0000,
		S_GOC   = 10'b00_1000_0000,
		S_DIVC  = 10'b01_0000_0000,
		S_EMIT  = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_nxt;
	end

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (func == seio_pkg::FUNC_START) begin
						cmd.load    = 1'b1;
						cmd.div_go  = 1'b1;
						cmd.div_sel = seio_pkg::DIV_INT;
						state_nxt   = S_DIVI;
					end else if (sts.moving) begin
						if (sts.tick_hit) begin
							cmd.step_adv = 1'b1;
							state_nxt    = S_CALCF;
						end else begin
							cmd.tick_inc = 1'b1;
						end
					end
				end
			end
			S_DIVI: begin
				cmd.div_sel = seio_pkg::DIV_INT;
				if (sts.div_done) begin
					cmd.set_int = 1'b1;
					state_nxt   = S_CALCF;
				end
			end
			S_CALCF: begin
				cmd.calc_f = 1'b1;
				state_nxt  = S_NUM;
			end
			S_NUM: begin
				cmd.calc_num = 1'b1;
				state_nxt    = S_GOA;
			end
			S_GOA: begin
				cmd.div_go  = 1'b1;
				cmd.div_sel = seio_pkg::DIV_ANG;
				state_nxt   = S_DIVA;
			end
			S_DIVA: begin
				cmd.div_sel = seio_pkg::DIV_ANG;
				if (sts.div_done) begin
					cmd.lat_angle = 1'b1;
					state_nxt     = S_PROD;
				end
			end
			S_PROD: begin
				cmd.calc_prod = 1'b1;
				state_nxt     = S_GOC;
			end
			S_GOC: begin
				cmd.div_go  = 1'b1;
				cmd.div_sel = seio_pkg::DIV_CMP;
				state_nxt   = S_DIVC;
			end
			S_DIVC: begin
				cmd.div_sel = seio_pkg::DIV_CMP;
				if (sts.div_done)
					state_nxt = S_EMIT;
			end
			S_EMIT: begin
				cmd.div_sel = seio_pkg::DIV_CMP;
				if (!sts.out_busy) begin
					cmd.emit  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	assign in_stall = (state_q != S_IDLE);

endmodule
`default_nettype wire

FILE: rtl/servo_ease_in_out_trajectory_unit.sv
// Top level of the servo ease-in-out trajectory unit.
`default_nettype none
`include "servo_ease_in_out_trajectory_unit_defines.svh"
// Servo move generator with quadratic ease-in-out. A start request (func 0)
// latches start and end angle, duration and timer channel, works out the
// step interval max(1, duration_ms / STEPS) and emits step 0. Each tick
// request (func 1, one per millisecond) counts toward that interval; when it
// is reached the next step is emitted, up to step STEPS, which carries last
// and ends the move. Ticks while no move runs are dropped without a result,
// and a start during a move restarts it. Each step's angle is
// floor((start*S^2 + (end-start)*f) / S^2) with f the exact integer easing
// curve, then mapped to pulse_min + trunc(angle*(pulse_max-pulse_min)/180),
// wrapped to 16 bits. Timing: every division is by a constant and runs on one
// shared unit that multiplies by a fixed reciprocal; it registers the
// operand, then the product with its done flag. A tick that emits a step
// holds in_stall high through the easing, angle division, product, pulse
// division and emit states; a start request adds the interval division.
// in_stall is high while a request is in progress. The result sits in an
// output register, so the next request is taken while it waits; only the
// following emit waits for it to drain, which stretches that request by
// the stall. Config registers pulse_min (index 0, reset 500) and pulse_max
// (index 1, reset 2500) are for the user to write only while the unit is
// idle; the unit itself does not enforce this.
module servo_ease_in_out_trajectory_unit #(
	parameter int unsigned STEPS = 200
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// config write port
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data,
	// request channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        func,
	input  wire logic [7:0]  start_angle,
	input  wire logic [7:0]  end_angle,
	input  wire logic [15:0] duration_ms,
	input  wire logic [1:0]  channel,
	// result channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [15:0]      compare_value,
	output logic [1:0]       out_channel,
	output logic [7:0]       step_index,
	output logic             last
);
	seio_pkg::cmd_t cmd;
	seio_pkg::sts_t sts;

	// Sequencer: decides per request which datapath steps run.
	seio_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.func     (func),
		.in_stall (in_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	// Datapath: move state, arithmetic, shared divider, output register.
	seio_dp #(
		.STEPS (STEPS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.start_angle   (start_angle),
		.end_angle     (end_angle),
		.duration_ms   (duration_ms),
		.channel       (channel),
		.cmd           (cmd),
		.sts           (sts),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.compare_value (compare_value),
		.out_channel   (out_channel),
		.step_index    (step_index),
		.last          (last)
	);

	// A start request always needs the divider, so the unit is busy next cycle.
	`SEIO_ASSERT_NEXT(a_start_busy, in_valid && !in_stall && func == seio_pkg::FUNC_START, in_stall, "start request did not occupy the unit")
	// A tick with no move running is dropped at once.
	`SEIO_ASSERT_NEXT(a_idle_tick, in_valid && !in_stall && func == seio_pkg::FUNC_TICK && !sts.moving, !in_stall, "idle tick left the unit busy")
	// last marks exactly the final step.
	`SEIO_ASSERT_IMPL(a_last_step, out_valid, last == (step_index == 8'(STEPS)), "last flag disagrees with step index")

endmodule
`default_nettype wire
